// ===== sv/atoi_pkg.sv =====
`default_nettype none
package atoi_pkg;

  // one input word: a character and the start-of-string mark
  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
  } item_t;

  // one result word
  typedef struct packed {
    logic [31:0] parsed_value;
    logic [8:0]  consumed_count;
  } result_t;

  // radix constants
  localparam logic [5:0] BASE_MAX   = 6'd36;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_AUTO  = 6'd0;
  localparam logic [5:0] DIGIT_NONE = 6'd36;

  // character classes worked out by the front end
  typedef struct packed {
    logic       first;
    logic [5:0] base;    // base register, captured with the word
    logic       blank;   // space or tab
    logic       zero;    // '0'
    logic       minus;
    logic       plus;
    logic       hex_x;   // 'x' or 'X'
    logic [5:0] digit;   // 0..35, DIGIT_NONE if not alphanumeric
  } class_t;

  // parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

endpackage
`default_nettype wire

// ===== sv/atoi_fifo.sv =====
`default_nettype none
module atoi_fifo #(
  parameter type word_t = logic [0:0]
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr,
  input  word_t      wr_data,
  output logic       full,
  input  wire logic  rd,
  output word_t      rd_data,
  output logic       empty
);

  // two-entry queue
  word_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        wr_en;
  logic        rd_en;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign wr_en   = wr && !full;
  assign rd_en   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (rd_en) rd_ptr <= !rd_ptr;
      if (wr_en && !rd_en) count <= count + 2'd1;
      else if (rd_en && !wr_en) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

// ===== sv/atoi_front.sv =====
`default_nettype none
module atoi_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            base_we,
  input  wire logic [5:0]      base_data,
  input  atoi_pkg::item_t      item,
  output atoi_pkg::class_t     cls
);
  import atoi_pkg::*;

  logic [5:0] number_base;

  // digit value of a character, DIGIT_NONE if not alphanumeric
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [5:0] d;
    d = DIGIT_NONE;
    if (c >= "0" && c <= "9") d = 6'(c - "0");
    else if (c >= "a" && c <= "z") d = 6'(c - "a") + 6'd10;
    else if (c >= "A" && c <= "Z") d = 6'(c - "A") + 6'd10;
    return d;
  endfunction

  // base register
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_DEC;
    end else if (base_we) begin
      number_base <= base_data;
    end
  end

  // classify the incoming character
  always_comb begin
    cls.first = item.first_char;
    cls.base  = number_base;
    cls.blank = (item.char_code == " ") || (item.char_code == 8'h09);
    cls.zero  = (item.char_code == "0");
    cls.minus = (item.char_code == "-");
    cls.plus  = (item.char_code == "+");
    cls.hex_x = (item.char_code == "x") || (item.char_code == "X");
    cls.digit = digit_of(item.char_code);
  end

endmodule
`default_nettype wire

// ===== sv/atoi_back.sv =====
`default_nettype none
module atoi_back #(
  parameter int MAX_LEN = 256
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  atoi_pkg::class_t     q_word,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output atoi_pkg::result_t    result,
  output logic                 empty,
  input  wire logic            pop
);
  import atoi_pkg::*;

  localparam logic [8:0] COUNT_LIMIT = 9'((MAX_LEN < 511) ? MAX_LEN : 511);

  phase_t      phase, phase_next;
  logic [5:0]  act_base, act_base_next;
  logic        negative, negative_next;
  logic [31:0] acc, acc_next;
  logic [8:0]  cnt, cnt_next;
  logic        go;
  logic        emit;
  logic        o_full;
  result_t     res_word;

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      act_base <= 6'd0;
      negative <= 1'b0;
      acc      <= 32'd0;
      cnt      <= 9'd0;
    end else begin
      phase    <= phase_next;
      act_base <= act_base_next;
      negative <= negative_next;
      acc      <= acc_next;
      cnt      <= cnt_next;
    end
  end

  // one character per cycle unless the result queue is full: restart, prefix handling, multiply-add
  always_comb begin
    logic inc;
    logic do_digit;
    logic [31:0] prod;
    inc           = 1'b0;
    do_digit      = 1'b0;
    prod          = 32'd0;
    phase_next    = phase;
    act_base_next = act_base;
    negative_next = negative;
    acc_next      = acc;
    cnt_next      = cnt;
    emit          = 1'b0;
    go            = !q_empty && !o_full;
    q_pop         = go;

    if (go) begin
      // new string restarts the parser
      if (q_word.first) begin
        act_base_next = q_word.base;
        negative_next = 1'b0;
        acc_next      = 32'd0;
        cnt_next      = 9'd0;
        phase_next    = PH_LEAD;
        if (q_word.base > BASE_MAX) begin
          // unusable radix: answer at once with nothing consumed
          act_base_next = 6'd0;
          phase_next    = PH_DONE;
          emit          = 1'b1;
        end
      end

      if (!emit) begin
        unique case (phase_next)
          PH_LEAD: begin
            if (q_word.blank) begin
              inc = 1'b1;
            end else if (q_word.zero && act_base_next == BASE_AUTO) begin
              inc        = 1'b1;
              phase_next = PH_ZERO;
            end else begin
              if (act_base_next == BASE_AUTO) act_base_next = BASE_DEC;
              phase_next = PH_DIGITS;
              if (q_word.minus || q_word.plus) begin
                negative_next = q_word.minus;
                inc           = 1'b1;
              end else begin
                do_digit = 1'b1;
              end
            end
          end
          PH_ZERO: begin
            phase_next = PH_DIGITS;
            if (q_word.hex_x) begin
              act_base_next = BASE_HEX;
              inc           = 1'b1;
            end else begin
              act_base_next = BASE_OCT;
              do_digit      = 1'b1;
            end
          end
          PH_DIGITS: do_digit = 1'b1;
          default: ;
        endcase

        if (do_digit) begin
          if (q_word.digit >= act_base_next) begin
            emit       = 1'b1;
            phase_next = PH_DONE;
          end else begin
            prod = acc_next * {26'd0, act_base_next};
            if (negative_next) acc_next = prod - {26'd0, q_word.digit};
            else acc_next = prod + {26'd0, q_word.digit};
            inc = 1'b1;
          end
        end

        // saturating character count
        if (inc && cnt_next < COUNT_LIMIT) cnt_next = cnt_next + 9'd1;
      end
    end

    res_word.parsed_value   = acc_next;
    res_word.consumed_count = cnt_next;
  end

  // result queue decouples the parser from the consumer
  atoi_fifo #(
    .word_t (result_t)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (emit),
    .wr_data (res_word),
    .full    (o_full),
    .rd      (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
`default_nettype wire

// ===== sv/ascii_to_integer_parser_top.sv =====
`default_nettype none
// Streaming ASCII to integer parser, one character word per cycle while not stalled.
// Throughput: one character per cycle while neither queue is full, with a single
// 32x6 multiply-add on the accumulator in the back end.
// Path: a stopping character is written into the character queue, parsed
// combinationally by the back end when it reaches the queue head and the result
// queue has room, and its result is then written into the result queue.
// Reset (rst, synchronous): queues empty, parser idle, base register 10.
module ascii_to_integer_parser_top #(
  parameter int MAX_LEN = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  atoi_pkg::item_t    item,
  output logic               empty,
  input  wire logic          pop,
  output atoi_pkg::result_t  result,
  input  wire logic          base_we,
  input  wire logic [5:0]    base_data
);
  import atoi_pkg::*;

  class_t cls;
  class_t q_word;
  logic   q_empty;
  logic   q_pop;

  // front end: base register and character classes
  atoi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .base_we   (base_we),
    .base_data (base_data),
    .item      (item),
    .cls       (cls)
  );

  // classified word queue between front and back
  atoi_fifo #(
    .word_t (class_t)
  ) u_char_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (cls),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_word),
    .empty   (q_empty)
  );

  // back end: parser and result queue
  atoi_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_word  (q_word),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  // checks
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_result_needs_char: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(q_pop))
    else $error("result appeared without a parsed character");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !q_empty)
    else $error("accepted character missing from queue");

endmodule
`default_nettype wire
